// File: hw/rtl/auvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// auvd_pkg
// Shared types, codes and the step schedule of the actuator dynamics block.
// ----------------------------------------------------------------------------
package auvd_pkg;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_YAW  = 2'd2;

    // Request operation codes.
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Sequencer steps.
    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_FIRST     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_OUT_FIRST = 5'd24;
    localparam logic [STEP_W-1:0] STEP_LAST      = 5'd26;

    // Operand and destination codes of the datapath register set.
    typedef enum logic [5:0] {
        REG_ZERO,
        REG_PS, REG_PA, REG_V, REG_A, REG_R, REG_RR, REG_Y, REG_YR,
        REG_D_PS, REG_D_PA, REG_D_V, REG_D_A, REG_D_RR, REG_D_YR,
        REG_RUD_RAD, REG_PB_POW, REG_VA00_V, REG_VB_PS, REG_VA11_A,
        REG_VV, REG_YB_R, REG_YA11_YR, REG_SF, REG_DRIVE,
        REG_RPM, REG_YAW_DEG,
        REG_POWER, REG_RUD, REG_DT, REG_SFS,
        REG_K_DEG2RAD, REG_K_500, REG_K_A00, REG_K_VELB, REG_K_VA11,
        REG_K_YAWB, REG_K_YA11, REG_K_RPM, REG_K_R2D
    } t_reg;

    typedef enum logic [1:0] {
        OP_MUL,      // sat(c + round(a*b))
        OP_MUL_RAW,  // sat(c + a*b), no fraction shift
        OP_SUM       // sat(a - b - k*c)
    } t_op;

    typedef struct packed {
        logic       issue;
        t_op        op;
        t_reg       a;
        t_reg       b;
        t_reg       c;
        t_reg       dest;
        logic [1:0] k;
    } t_uop;

    typedef struct packed {
        logic load;
        logic restart;
        logic publish;
        t_uop uop;
    } t_dp_cmd;

    localparam t_uop UOP_NOP = '{issue: 1'b0, op: OP_MUL, a: REG_ZERO, b: REG_ZERO,
                                 c: REG_ZERO, dest: REG_ZERO, k: 2'd0};

    function automatic t_uop mul(input t_op op, input t_reg a, input t_reg b,
                                 input t_reg c, input t_reg dest);
        t_uop u;
        u = '{issue: 1'b1, op: op, a: a, b: b, c: c, dest: dest, k: 2'd0};
        return u;
    endfunction

    function automatic t_uop sum(input t_reg a, input t_reg b, input t_reg c,
                                 input logic [1:0] k, input t_reg dest);
        t_uop u;
        u = '{issue: 1'b1, op: OP_SUM, a: a, b: b, c: c, dest: dest, k: k};
        return u;
    endfunction

    // One operation is issued per step; its result can be read once it is written back.
    // All derivatives use the old state; all but the yaw-rate one precede the first update.
    function automatic t_uop uop_at(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mul(OP_MUL, REG_RUD, REG_K_DEG2RAD, REG_ZERO, REG_RUD_RAD);
            5'd1:  u = mul(OP_MUL_RAW, REG_POWER, REG_K_500, REG_ZERO, REG_PB_POW);
            5'd2:  u = mul(OP_MUL, REG_K_A00, REG_V, REG_ZERO, REG_VA00_V);
            5'd3:  u = mul(OP_MUL, REG_K_VELB, REG_PS, REG_ZERO, REG_VB_PS);
            5'd4:  u = mul(OP_MUL, REG_K_VA11, REG_A, REG_ZERO, REG_VA11_A);
            5'd5:  u = mul(OP_MUL, REG_V, REG_V, REG_ZERO, REG_VV);
            5'd6:  u = mul(OP_MUL, REG_K_YAWB, REG_R, REG_ZERO, REG_YB_R);
            5'd7:  u = mul(OP_MUL, REG_K_YA11, REG_YR, REG_ZERO, REG_YA11_YR);
            5'd8:  u = sum(REG_PA, REG_PS, REG_ZERO, 2'd0, REG_D_PS);
            5'd9:  u = sum(REG_PB_POW, REG_ZERO, REG_PA, 2'd2, REG_D_PA);
            5'd10: u = sum(REG_A, REG_VA00_V, REG_ZERO, 2'd0, REG_D_V);
            5'd11: u = sum(REG_VB_PS, REG_VA11_A, REG_ZERO, 2'd0, REG_D_A);
            5'd12: u = sum(REG_RUD_RAD, REG_R, REG_RR, 2'd3, REG_D_RR);
            5'd13: u = mul(OP_MUL, REG_VV, REG_SFS, REG_ZERO, REG_SF);
            5'd14: u = mul(OP_MUL, REG_D_PS, REG_DT, REG_PS, REG_PS);
            5'd15: u = mul(OP_MUL, REG_YB_R, REG_SF, REG_ZERO, REG_DRIVE);
            5'd16: u = mul(OP_MUL, REG_D_PA, REG_DT, REG_PA, REG_PA);
            5'd17: u = sum(REG_DRIVE, REG_YA11_YR, REG_ZERO, 2'd0, REG_D_YR);
            5'd18: u = mul(OP_MUL, REG_D_V, REG_DT, REG_V, REG_V);
            5'd19: u = mul(OP_MUL, REG_D_A, REG_DT, REG_A, REG_A);
            5'd20: u = mul(OP_MUL, REG_RR, REG_DT, REG_R, REG_R);
            5'd21: u = mul(OP_MUL, REG_D_RR, REG_DT, REG_RR, REG_RR);
            5'd22: u = mul(OP_MUL, REG_YR, REG_DT, REG_Y, REG_Y);
            5'd23: u = mul(OP_MUL, REG_D_YR, REG_DT, REG_YR, REG_YR);
            5'd24: u = mul(OP_MUL, REG_PS, REG_K_RPM, REG_ZERO, REG_RPM);
            5'd25: u = mul(OP_MUL, REG_Y, REG_K_R2D, REG_ZERO, REG_YAW_DEG);
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/auvd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// auvd_if
// Request and result channels of the actuator dynamics block.
// ----------------------------------------------------------------------------
interface auvd_cmd_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] power_cmd;
    logic signed [31:0] rudder_cmd;

    modport source (output valid, output operation, output power_cmd,
                    output rudder_cmd, input ready);
    modport sink   (input valid, input operation, input power_cmd,
                    input rudder_cmd, output ready);
endinterface

interface auvd_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rpm_out;
    logic signed [31:0] speed_out;
    logic signed [31:0] yaw_deg;
    logic               saturated;

    modport source (output valid, output rpm_out, output speed_out,
                    output yaw_deg, output saturated, input ready);
    modport sink   (input valid, input rpm_out, input speed_out,
                    input yaw_deg, input saturated, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/auvd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// auvd_ctrl
// Sequencer: accepts a request, steps through the operation schedule and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module auvd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_operation,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output auvd_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [auvd_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_out_valid, n_out_valid;
    logic                        s_accept;
    logic                        s_publish;
    logic                        s_restart;

    assign s_accept  = i_in_valid && (r_state == S_IDLE);
    assign s_publish = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign s_restart = (i_operation == auvd_pkg::REQ_RESTART);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_RUN;
                    n_step  = s_restart ? auvd_pkg::STEP_OUT_FIRST : auvd_pkg::STEP_FIRST;
                end
            end
            S_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == auvd_pkg::STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (s_publish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s_publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= auvd_pkg::STEP_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.load    = s_accept;
        o_cmd.restart = s_accept && s_restart;
        o_cmd.publish = s_publish;
        o_cmd.uop     = (r_state == S_RUN) ? auvd_pkg::uop_at(r_step) : auvd_pkg::UOP_NOP;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: hw/rtl/auvd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// auvd_datapath
// State, scratch and configuration registers around one shared signed
// multiplier with a rounding, accumulate and saturate stage behind it.
// ----------------------------------------------------------------------------
module auvd_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire auvd_pkg::t_dp_cmd                i_cmd,
    input  wire logic signed [31:0]               i_power_cmd,
    input  wire logic signed [31:0]               i_rudder_cmd,
    input  wire logic                             i_cfg_we,
    input  wire logic [auvd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [auvd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic signed [31:0]                    o_rpm_out,
    output logic signed [31:0]                    o_speed_out,
    output logic signed [31:0]                    o_yaw_deg,
    output logic                                  o_saturated
);

    localparam longint Q_ONE = longint'(1) << FRAC_BITS;

    localparam logic signed [31:0] K_ONE     = 32'(Q_ONE);
    localparam logic signed [31:0] K_RUD_LIM = 32'(20 * Q_ONE);
    localparam logic signed [31:0] K_DEG2RAD =
        32'((64'sd174532925199 * Q_ONE + 64'sd5000000000000) / 64'sd10000000000000);
    localparam logic signed [31:0] K_R2D =
        32'((64'sd57295779513 * Q_ONE + 64'sd500000000) / 64'sd1000000000);
    localparam logic signed [31:0] K_RPM =
        32'((64'sd9549296586 * Q_ONE + 64'sd500000000) / 64'sd1000000000);
    localparam logic signed [31:0] K_500  = 32'sd500;
    localparam logic signed [31:0] K_A00  = 32'(Q_ONE / 2);
    localparam logic signed [31:0] K_VA11 = 32'((3 * Q_ONE) / 4);
    localparam logic signed [31:0] K_VELB = 32'((15 * Q_ONE + 500) / 1000);
    localparam logic signed [31:0] K_YA11 = 32'((99 * Q_ONE + 50) / 100);
    localparam logic signed [31:0] K_YAWB = 32'((Q_ONE + 10) / 20);

    localparam logic signed [63:0] HALF    = 64'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Configuration.
    logic [16:0]        r_time_step;
    logic [30:0]        r_sfs;
    logic signed [18:0] r_init_yaw;

    // Dynamic state.
    logic signed [31:0] r_ps, r_pa, r_v, r_a, r_r, r_rr, r_y, r_yr;

    // Derivatives, products and clamped commands of the current tick.
    logic signed [31:0] r_d_ps, r_d_pa, r_d_v, r_d_a, r_d_rr, r_d_yr;
    logic signed [31:0] r_rud_rad, r_pb_pow, r_va00_v, r_vb_ps, r_va11_a;
    logic signed [31:0] r_vv, r_yb_r, r_ya11_yr, r_sf, r_drive;
    logic signed [31:0] r_rpm, r_yaw_deg, r_power, r_rud;

    // Multiplier stage.
    logic                r_p_valid;
    auvd_pkg::t_op       r_p_op;
    auvd_pkg::t_reg      r_p_dest;
    logic [1:0]          r_p_k;
    logic signed [31:0]  r_a_op, r_b_op, r_c_op;
    logic signed [63:0]  r_prod;

    logic                r_sat;

    logic signed [31:0] r_out_rpm, r_out_speed, r_out_yaw;
    logic               r_out_sat;

    logic signed [31:0] s_a, s_b, s_c;
    logic signed [63:0] s_prod;
    logic signed [63:0] s_round, s_kc, s_wide;
    logic signed [31:0] s_res;
    logic               s_res_sat;
    logic signed [31:0] s_power, s_rud;

    function automatic logic signed [31:0] read_reg(input auvd_pkg::t_reg code);
        logic signed [31:0] v;
        case (code)
            auvd_pkg::REG_PS:        v = r_ps;
            auvd_pkg::REG_PA:        v = r_pa;
            auvd_pkg::REG_V:         v = r_v;
            auvd_pkg::REG_A:         v = r_a;
            auvd_pkg::REG_R:         v = r_r;
            auvd_pkg::REG_RR:        v = r_rr;
            auvd_pkg::REG_Y:         v = r_y;
            auvd_pkg::REG_YR:        v = r_yr;
            auvd_pkg::REG_D_PS:      v = r_d_ps;
            auvd_pkg::REG_D_PA:      v = r_d_pa;
            auvd_pkg::REG_D_V:       v = r_d_v;
            auvd_pkg::REG_D_A:       v = r_d_a;
            auvd_pkg::REG_D_RR:      v = r_d_rr;
            auvd_pkg::REG_D_YR:      v = r_d_yr;
            auvd_pkg::REG_RUD_RAD:   v = r_rud_rad;
            auvd_pkg::REG_PB_POW:    v = r_pb_pow;
            auvd_pkg::REG_VA00_V:    v = r_va00_v;
            auvd_pkg::REG_VB_PS:     v = r_vb_ps;
            auvd_pkg::REG_VA11_A:    v = r_va11_a;
            auvd_pkg::REG_VV:        v = r_vv;
            auvd_pkg::REG_YB_R:      v = r_yb_r;
            auvd_pkg::REG_YA11_YR:   v = r_ya11_yr;
            auvd_pkg::REG_SF:        v = r_sf;
            auvd_pkg::REG_DRIVE:     v = r_drive;
            auvd_pkg::REG_RPM:       v = r_rpm;
            auvd_pkg::REG_YAW_DEG:   v = r_yaw_deg;
            auvd_pkg::REG_POWER:     v = r_power;
            auvd_pkg::REG_RUD:       v = r_rud;
            auvd_pkg::REG_DT:        v = {15'd0, r_time_step};
            auvd_pkg::REG_SFS:       v = {1'b0, r_sfs};
            auvd_pkg::REG_K_DEG2RAD: v = K_DEG2RAD;
            auvd_pkg::REG_K_500:     v = K_500;
            auvd_pkg::REG_K_A00:     v = K_A00;
            auvd_pkg::REG_K_VELB:    v = K_VELB;
            auvd_pkg::REG_K_VA11:    v = K_VA11;
            auvd_pkg::REG_K_YAWB:    v = K_YAWB;
            auvd_pkg::REG_K_YA11:    v = K_YA11;
            auvd_pkg::REG_K_RPM:     v = K_RPM;
            auvd_pkg::REG_K_R2D:     v = K_R2D;
            default:                 v = '0;
        endcase
        return v;
    endfunction

    // Operand selection and the multiply.
    always_comb begin
        s_a    = read_reg(i_cmd.uop.a);
        s_b    = read_reg(i_cmd.uop.b);
        s_c    = read_reg(i_cmd.uop.c);
        s_prod = s_a * s_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.uop.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_op   <= i_cmd.uop.op;
        r_p_dest <= i_cmd.uop.dest;
        r_p_k    <= i_cmd.uop.k;
        r_a_op   <= s_a;
        r_b_op   <= s_b;
        r_c_op   <= s_c;
        r_prod   <= s_prod;
    end

    // Round half up for OP_MUL, accumulate or subtract, then saturate to the 32-bit range.
    always_comb begin
        s_round = (r_prod + HALF) >>> FRAC_BITS;
        case (r_p_k)
            2'd1:    s_kc = 64'(r_c_op);
            2'd2:    s_kc = 64'(r_c_op) <<< 1;
            2'd3:    s_kc = 64'(r_c_op) + (64'(r_c_op) <<< 1);
            default: s_kc = '0;
        endcase
        case (r_p_op)
            auvd_pkg::OP_MUL:     s_wide = s_round + 64'(r_c_op);
            auvd_pkg::OP_MUL_RAW: s_wide = r_prod + 64'(r_c_op);
            auvd_pkg::OP_SUM:     s_wide = 64'(r_a_op) - 64'(r_b_op) - s_kc;
            default:              s_wide = '0;
        endcase
        if (s_wide > S32_MAX) begin
            s_res     = 32'(S32_MAX);
            s_res_sat = 1'b1;
        end else if (s_wide < S32_MIN) begin
            s_res     = 32'(S32_MIN);
            s_res_sat = 1'b1;
        end else begin
            s_res     = s_wide[31:0];
            s_res_sat = 1'b0;
        end
    end

    // Command clamps.
    always_comb begin
        if (i_power_cmd < 32'sd0) begin
            s_power = '0;
        end else if (i_power_cmd > K_ONE) begin
            s_power = K_ONE;
        end else begin
            s_power = i_power_cmd;
        end
        if (i_rudder_cmd < -K_RUD_LIM) begin
            s_rud = -K_RUD_LIM;
        end else if (i_rudder_cmd > K_RUD_LIM) begin
            s_rud = K_RUD_LIM;
        end else begin
            s_rud = i_rudder_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= 17'd655;
            r_sfs       <= 31'd655;
            r_init_yaw  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                auvd_pkg::CFG_TIME_STEP:    r_time_step <= i_cfg_data[16:0];
                auvd_pkg::CFG_SPEED_FACTOR: r_sfs       <= i_cfg_data[30:0];
                auvd_pkg::CFG_INITIAL_YAW:  r_init_yaw  <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= '0;
            r_pa  <= '0;
            r_v   <= '0;
            r_a   <= '0;
            r_r   <= '0;
            r_rr  <= '0;
            r_y   <= '0;
            r_yr  <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.load) begin
            r_sat <= 1'b0;
            if (i_cmd.restart) begin
                r_ps <= '0;
                r_pa <= '0;
                r_v  <= '0;
                r_a  <= '0;
                r_r  <= '0;
                r_rr <= '0;
                r_y  <= 32'(r_init_yaw);
                r_yr <= '0;
            end
        end else if (r_p_valid) begin
            r_sat <= r_sat | s_res_sat;
            case (r_p_dest)
                auvd_pkg::REG_PS: r_ps <= s_res;
                auvd_pkg::REG_PA: r_pa <= s_res;
                auvd_pkg::REG_V:  r_v  <= s_res;
                auvd_pkg::REG_A:  r_a  <= s_res;
                auvd_pkg::REG_R:  r_r  <= s_res;
                auvd_pkg::REG_RR: r_rr <= s_res;
                auvd_pkg::REG_Y:  r_y  <= s_res;
                auvd_pkg::REG_YR: r_yr <= s_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_power <= s_power;
            r_rud   <= s_rud;
        end else if (r_p_valid) begin
            case (r_p_dest)
                auvd_pkg::REG_D_PS:    r_d_ps    <= s_res;
                auvd_pkg::REG_D_PA:    r_d_pa    <= s_res;
                auvd_pkg::REG_D_V:     r_d_v     <= s_res;
                auvd_pkg::REG_D_A:     r_d_a     <= s_res;
                auvd_pkg::REG_D_RR:    r_d_rr    <= s_res;
                auvd_pkg::REG_D_YR:    r_d_yr    <= s_res;
                auvd_pkg::REG_RUD_RAD: r_rud_rad <= s_res;
                auvd_pkg::REG_PB_POW:  r_pb_pow  <= s_res;
                auvd_pkg::REG_VA00_V:  r_va00_v  <= s_res;
                auvd_pkg::REG_VB_PS:   r_vb_ps   <= s_res;
                auvd_pkg::REG_VA11_A:  r_va11_a  <= s_res;
                auvd_pkg::REG_VV:      r_vv      <= s_res;
                auvd_pkg::REG_YB_R:    r_yb_r    <= s_res;
                auvd_pkg::REG_YA11_YR: r_ya11_yr <= s_res;
                auvd_pkg::REG_SF:      r_sf      <= s_res;
                auvd_pkg::REG_DRIVE:   r_drive   <= s_res;
                auvd_pkg::REG_RPM:     r_rpm     <= s_res;
                auvd_pkg::REG_YAW_DEG: r_yaw_deg <= s_res;
                default: ;
            endcase
        end
    end

    // Output register; it holds while a result waits to be taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_rpm   <= r_rpm;
            r_out_speed <= r_v;
            r_out_yaw   <= r_yaw_deg;
            r_out_sat   <= r_sat;
        end
    end

    assign o_rpm_out   = r_out_rpm;
    assign o_speed_out = r_out_speed;
    assign o_yaw_deg   = r_out_yaw;
    assign o_saturated = r_out_sat;

endmodule
`default_nettype wire

// File: hw/rtl/auv_actuator_dynamics_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// auv_actuator_dynamics_step
// One simulation tick of the vehicle's propeller, speed, rudder and yaw
// dynamics in signed fixed point.
// ----------------------------------------------------------------------------
// A tick request is accepted, runs the sequencer steps from STEP_FIRST to
// STEP_LAST and then loads the output register; a restart request runs only
// the steps from STEP_OUT_FIRST on. This is set by the single shared 32x32
// multiplier, which takes one operation per step and registers each result,
// so the 20 multiplies and 6 sums of a tick run in sequence. A new request
// is accepted in the cycle after the previous result is loaded, even while
// that result still waits to be taken. The user must see that configuration is
// written only while no request is in progress; the block does not enforce it.
module auv_actuator_dynamics_step #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    auvd_cmd_if.sink                              i_cmd,
    auvd_res_if.source                            o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [auvd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [auvd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    auvd_pkg::t_dp_cmd s_cmd;
    logic              s_in_ready;
    logic              s_out_valid;

    auvd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_operation (i_cmd.operation),
        .o_in_ready  (s_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (s_out_valid),
        .o_cmd       (s_cmd)
    );

    auvd_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .i_power_cmd  (i_cmd.power_cmd),
        .i_rudder_cmd (i_cmd.rudder_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_rpm_out    (o_res.rpm_out),
        .o_speed_out  (o_res.speed_out),
        .o_yaw_deg    (o_res.yaw_deg),
        .o_saturated  (o_res.saturated)
    );

    assign i_cmd.ready = s_in_ready;
    assign o_res.valid = s_out_valid;

endmodule
`default_nettype wire
